// ----- hdl/rotary_encoder_button_decoder_unit_defines.svh -----
// Assertion macros shared by rebd_turns.sv and rotary_encoder_button_decoder_unit.sv.
`ifndef ROTARY_ENCODER_BUTTON_DECODER_UNIT_DEFINES_SVH
`define ROTARY_ENCODER_BUTTON_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTH

// Condition that must hold at every clock edge out of reset.
`define REBD_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define REBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define REBD_ASSERT(label, expr, msg)
`define REBD_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- hdl/rebd_pkg.sv -----
package rebd_pkg;

  localparam int TURN_DEPTH_DEF = 16;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_INVERT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_INVERT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TURNS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLICK_MIN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CLICK_MAX     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MIN      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CLICKS_GAP    = 3'd7;

  localparam logic [1:0]  STEP_MODE_RST     = 2'd0;
  localparam logic        DIR_INVERT_RST    = 1'b0;
  localparam logic        BUTTON_INVERT_RST = 1'b1;
  localparam logic [4:0]  MAX_TURNS_RST     = 5'd16;
  localparam logic [15:0] CLICK_MIN_RST     = 16'd50;
  localparam logic [15:0] CLICK_MAX_RST     = 16'd500;
  localparam logic [15:0] HOLD_MIN_RST      = 16'd600;
  localparam logic [15:0] CLICKS_GAP_RST    = 16'd400;

  localparam logic [3:0] COUNT_SAT = 4'd15;

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_POP    = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_ACK    = 2'd3
  } action_e_t;

  typedef struct packed {
    action_e_t  action;
    logic       clk_level;
    logic       dt_level;
    logic       button_level;
    logic [3:0] ack_mask;
  } in_item_t;

  typedef struct packed {
    logic       turn_available;
    logic       head_right;
    logic       head_with_button;
    logic [4:0] turns_stored;
    logic       pressed_event;
    logic       click_event;
    logic       held_event;
    logic [3:0] click_count;
    logic       clicks_final;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic right;
    logic with_btn;
    logic pop;
    logic clear;
  } fifo_ctl_t;

  typedef struct packed {
    logic       avail;
    logic       head_right;
    logic       head_btn;
    logic [4:0] stored;
  } fifo_stat_t;

  typedef struct packed {
    logic [15:0] click_min;
    logic [15:0] click_max;
    logic [15:0] hold_min;
    logic [15:0] clicks_gap;
  } btn_cfg_t;

  typedef struct packed {
    logic       valid;
    logic       sample;
    logic       turn;
    logic       level;
    logic       ack;
    logic [3:0] ack_mask;
    logic       inv_toggle;
  } btn_ctl_t;

  typedef struct packed {
    logic       pressed;
    logic       click;
    logic       held;
    logic [3:0] count;
    logic       final_flag;
  } btn_stat_t;

endpackage

// ----- hdl/rebd_turns.sv -----
`include "rotary_encoder_button_decoder_unit_defines.svh"

module rebd_turns #(
  parameter int TURN_DEPTH = rebd_pkg::TURN_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rebd_pkg::fifo_ctl_t  ctl,
  input  logic [4:0]           max_turns,
  output rebd_pkg::fifo_stat_t stat
);

  localparam int CW = $clog2(TURN_DEPTH + 1);
  localparam int IW = (TURN_DEPTH > 1) ? $clog2(TURN_DEPTH) : 1;
  localparam int W  = (CW > 5) ? CW : 5;

  logic [1:0]    rec_r   [TURN_DEPTH];
  logic [1:0]    rec_nxt [TURN_DEPTH];
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [W-1:0]  cap;
  logic          push_ok;
  logic          pop_ok;
  logic [IW-1:0] wr_idx;

  // capacity in use never exceeds the physical depth
  assign cap = (W'(max_turns) < W'(TURN_DEPTH)) ? W'(max_turns) : W'(TURN_DEPTH);
  assign push_ok = ctl.push && (W'(count_r) < cap);
  assign pop_ok  = ctl.pop && (count_r != '0);
  assign wr_idx  = count_r[IW-1:0];

  always_comb begin
    count_nxt = count_r;
    if (ctl.clear) begin
      count_nxt = '0;
    end else if (pop_ok) begin
      count_nxt = count_r - CW'(1);
    end else if (push_ok) begin
      count_nxt = count_r + CW'(1);
    end
  end

  // shift line: entry 0 is the oldest turn, entries above count hold don't-cares
  for (genvar i = 0; i < TURN_DEPTH; i++) begin : g_rec
    if (i < TURN_DEPTH - 1) begin : g_mid
      always_comb begin
        rec_nxt[i] = rec_r[i];
        if (pop_ok) begin
          rec_nxt[i] = rec_r[i+1];
        end else if (push_ok && wr_idx == IW'(i)) begin
          rec_nxt[i] = {ctl.with_btn, ctl.right};
        end
      end
    end else begin : g_last
      always_comb begin
        rec_nxt[i] = rec_r[i];
        if (pop_ok) begin
          rec_nxt[i] = 2'b00;
        end else if (push_ok && wr_idx == IW'(i)) begin
          rec_nxt[i] = {ctl.with_btn, ctl.right};
        end
      end
    end

    always_ff @(posedge clk) begin
      rec_r[i] <= rec_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_comb begin
    stat.avail      = (count_nxt != '0);
    stat.head_right = stat.avail && rec_nxt[0][0];
    stat.head_btn   = stat.avail && rec_nxt[0][1];
    stat.stored     = 5'(count_nxt);
  end

  `REBD_ASSERT(a_count_bound, count_r <= CW'(TURN_DEPTH), "turn count above depth")
  `REBD_ASSERT_NEXT(a_clear_empties, ctl.clear, count_r == '0, "clear left turns stored")
  `REBD_ASSERT_NEXT(a_push_counts, push_ok, count_r == CW'($past(count_r) + 1), "push lost")

endmodule

// ----- hdl/rebd_button.sv -----
module rebd_button (
  input  logic                clk,
  input  logic                rst_n,
  input  rebd_pkg::btn_cfg_t  cfg,
  input  rebd_pkg::btn_ctl_t  ctl,
  output rebd_pkg::btn_stat_t stat
);

  logic [31:0] now_r, press_r, rel_r, edge_r;
  logic [31:0] now_nxt, press_nxt, rel_nxt, edge_nxt;
  logic        prev_btn_r, prev_btn_nxt;
  logic        pressed_r, pressed_nxt;
  logic        click_r, click_nxt;
  logic        held_r, held_nxt;
  logic        final_r, final_nxt;
  logic [3:0]  count_r, count_nxt;
  logic        hold_rep_r, hold_rep_nxt;
  logic        turned_r, turned_nxt;

  logic [31:0] now_inc;
  logic [31:0] edge_gap;
  logic [31:0] delta;
  logic        multi;
  logic [31:0] press_age;
  logic [31:0] rel_age;
  logic        fin;
  logic        pressed_now;

  assign now_inc  = now_r + 32'd1;
  assign edge_gap = now_inc - edge_r;
  assign delta    = now_inc - press_r;
  assign multi    = (press_r - rel_r) <= 32'(cfg.clicks_gap);

  always_comb begin
    now_nxt      = now_r;
    press_nxt    = press_r;
    rel_nxt      = rel_r;
    edge_nxt     = edge_r;
    prev_btn_nxt = prev_btn_r;
    pressed_nxt  = pressed_r;
    click_nxt    = click_r;
    held_nxt     = held_r;
    final_nxt    = final_r;
    count_nxt    = count_r;
    hold_rep_nxt = hold_rep_r;
    turned_nxt   = turned_r;

    if (ctl.sample) begin
      now_nxt = now_inc;
    end
    if (ctl.turn) begin
      turned_nxt = 1'b1;
    end

    // button edge, only on samples without a turn; edges too close are ignored
    if (ctl.sample && !ctl.turn && ctl.level != prev_btn_r) begin
      prev_btn_nxt = ctl.level;
      if (edge_gap >= 32'(cfg.click_min)) begin
        edge_nxt = now_inc;
        if (ctl.level) begin
          press_nxt    = now_inc;
          hold_rep_nxt = 1'b0;
          turned_nxt   = 1'b0;
          pressed_nxt  = 1'b1;
        end else if (turned_r) begin
          turned_nxt = 1'b0;
        end else begin
          rel_nxt = now_inc;
          if (delta < 32'(cfg.click_min)) begin
            pressed_nxt = 1'b0;
          end else if (delta <= 32'(cfg.click_max)) begin
            click_nxt = 1'b1;
            if (!multi) begin
              count_nxt = 4'd1;
              final_nxt = 1'b0;
            end else if (count_r < rebd_pkg::COUNT_SAT) begin
              count_nxt = count_r + 4'd1;
            end
          end else if (delta >= 32'(cfg.hold_min) && !hold_rep_r) begin
            held_nxt     = 1'b1;
            hold_rep_nxt = 1'b1;
          end
        end
      end
    end

    // hold and series-end checks run after every request
    press_age = now_nxt - press_nxt;
    rel_age   = now_nxt - rel_nxt;
    if (!hold_rep_nxt && prev_btn_nxt && !turned_nxt &&
        press_age >= 32'(cfg.hold_min)) begin
      held_nxt     = 1'b1;
      hold_rep_nxt = 1'b1;
    end
    if (count_nxt != 4'd0 && !final_nxt && rel_age > 32'(cfg.clicks_gap)) begin
      final_nxt = 1'b1;
    end

    fin = (count_nxt != 4'd0) && final_nxt;
    pressed_now = pressed_nxt && (press_age >= 32'(cfg.click_min));
    if (ctl.ack) begin
      if (ctl.ack_mask[0] && pressed_now) begin
        pressed_nxt = 1'b0;
      end
      if (ctl.ack_mask[1]) begin
        click_nxt = 1'b0;
      end
      if (ctl.ack_mask[2]) begin
        held_nxt = 1'b0;
      end
      if (ctl.ack_mask[3] && fin) begin
        count_nxt = 4'd0;
        final_nxt = 1'b0;
      end
    end

    stat.pressed    = pressed_nxt && (press_age >= 32'(cfg.click_min));
    stat.click      = click_nxt;
    stat.held       = held_nxt;
    stat.count      = count_nxt;
    stat.final_flag = (count_nxt != 4'd0) && final_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r      <= '0;
      press_r    <= '0;
      rel_r      <= '0;
      edge_r     <= '0;
      prev_btn_r <= 1'b0;
      pressed_r  <= 1'b0;
      click_r    <= 1'b0;
      held_r     <= 1'b0;
      final_r    <= 1'b0;
      count_r    <= '0;
      hold_rep_r <= 1'b0;
      turned_r   <= 1'b0;
    end else begin
      if (ctl.valid) begin
        now_r      <= now_nxt;
        press_r    <= press_nxt;
        rel_r      <= rel_nxt;
        edge_r     <= edge_nxt;
        pressed_r  <= pressed_nxt;
        click_r    <= click_nxt;
        held_r     <= held_nxt;
        final_r    <= final_nxt;
        count_r    <= count_nxt;
        hold_rep_r <= hold_rep_nxt;
        turned_r   <= turned_nxt;
      end
      // flipping the active level flips the remembered level with it
      prev_btn_r <= (ctl.valid ? prev_btn_nxt : prev_btn_r) ^ ctl.inv_toggle;
    end
  end

endmodule

// ----- hdl/rotary_encoder_button_decoder_unit.sv -----
// Channel  Dir  Ports                          Taken when
// in       in   in_valid, in_stall, in_data    in_valid && !in_stall
// out      out  out_valid, out_stall, out_data out_valid && !out_stall
// cfg      in   cfg_we, cfg_index, cfg_data    cfg_we
//
// One request per cycle while in_stall is low; its result is in the output register in the next cycle.
// Decode, turn store and button logic all settle in the accepting cycle.
// Synchronous active-low reset; no clearing pass, ready right after reset.
// in_stall rises only while a result is held and out_stall is high.
`include "rotary_encoder_button_decoder_unit_defines.svh"

module rotary_encoder_button_decoder_unit #(
  parameter int TURN_DEPTH = rebd_pkg::TURN_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  rebd_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output rebd_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [rebd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rebd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [1:0]  step_mode_r;
  logic        dir_inv_r;
  logic        btn_inv_r;
  logic [4:0]  max_turns_r;
  logic [15:0] click_min_r, click_max_r, hold_min_r, clicks_gap_r;

  logic        prev_clk_r, prev_clk_nxt;
  logic        prev_dt_r, prev_dt_nxt;
  logic [7:0]  pulse_r, pulse_nxt;

  logic                 out_valid_r, out_valid_nxt;
  rebd_pkg::out_item_t  out_data_r, out_data_nxt;

  logic        acc;
  logic        is_sample;
  logic        trans;
  logic [7:0]  pulse_step;
  logic        mode_ok;
  logic        turn_vld;
  logic        turn_right;
  logic        active;
  logic        inv_toggle;

  rebd_pkg::fifo_ctl_t  fctl;
  rebd_pkg::fifo_stat_t fstat;
  rebd_pkg::btn_cfg_t   bcfg;
  rebd_pkg::btn_ctl_t   bctl;
  rebd_pkg::btn_stat_t  bstat;

  assign in_stall  = out_valid_r && out_stall;
  assign acc       = in_valid && !in_stall;
  assign is_sample = acc && (in_data.action == rebd_pkg::ACT_SAMPLE);

  // configuration
  assign inv_toggle = cfg_we && (cfg_index == rebd_pkg::CFG_BUTTON_INVERT) &&
                      (cfg_data[0] != btn_inv_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_mode_r  <= rebd_pkg::STEP_MODE_RST;
      dir_inv_r    <= rebd_pkg::DIR_INVERT_RST;
      btn_inv_r    <= rebd_pkg::BUTTON_INVERT_RST;
      max_turns_r  <= rebd_pkg::MAX_TURNS_RST;
      click_min_r  <= rebd_pkg::CLICK_MIN_RST;
      click_max_r  <= rebd_pkg::CLICK_MAX_RST;
      hold_min_r   <= rebd_pkg::HOLD_MIN_RST;
      clicks_gap_r <= rebd_pkg::CLICKS_GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rebd_pkg::CFG_STEP_MODE:     step_mode_r  <= cfg_data[1:0];
        rebd_pkg::CFG_DIR_INVERT:    dir_inv_r    <= cfg_data[0];
        rebd_pkg::CFG_BUTTON_INVERT: btn_inv_r    <= cfg_data[0];
        rebd_pkg::CFG_MAX_TURNS:     max_turns_r  <= cfg_data[4:0];
        rebd_pkg::CFG_CLICK_MIN:     click_min_r  <= cfg_data;
        rebd_pkg::CFG_CLICK_MAX:     click_max_r  <= cfg_data;
        rebd_pkg::CFG_HOLD_MIN:      hold_min_r   <= cfg_data;
        rebd_pkg::CFG_CLICKS_GAP:    clicks_gap_r <= cfg_data;
      endcase
    end
  end

  // quadrature decode: a legal transition flips the parity of the four levels
  assign trans = prev_clk_r ^ prev_dt_r ^ in_data.clk_level ^ in_data.dt_level;
  assign pulse_step = (in_data.clk_level ^ prev_dt_r) ? pulse_r + 8'd1 : pulse_r - 8'd1;

  always_comb begin
    unique case (step_mode_r)
      2'd0:    mode_ok = 1'b1;
      2'd1:    mode_ok = !(in_data.clk_level ^ in_data.dt_level);
      default: mode_ok = in_data.clk_level && in_data.dt_level;
    endcase
  end

  assign turn_vld   = is_sample && trans && (pulse_step != 8'd0) && mode_ok;
  assign turn_right = !pulse_step[7] ^ dir_inv_r;
  assign active     = in_data.button_level ^ btn_inv_r;

  always_comb begin
    prev_clk_nxt = prev_clk_r;
    prev_dt_nxt  = prev_dt_r;
    pulse_nxt    = pulse_r;
    if (is_sample && trans) begin
      prev_clk_nxt = in_data.clk_level;
      prev_dt_nxt  = in_data.dt_level;
      pulse_nxt    = turn_vld ? 8'd0 : pulse_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_clk_r <= 1'b1;
      prev_dt_r  <= 1'b1;
      pulse_r    <= '0;
    end else begin
      prev_clk_r <= prev_clk_nxt;
      prev_dt_r  <= prev_dt_nxt;
      pulse_r    <= pulse_nxt;
    end
  end

  // turn store
  always_comb begin
    fctl.push     = turn_vld;
    fctl.right    = turn_right;
    fctl.with_btn = active;
    fctl.pop      = acc && (in_data.action == rebd_pkg::ACT_POP);
    fctl.clear    = acc && (in_data.action == rebd_pkg::ACT_CLEAR);
  end

  rebd_turns #(
    .TURN_DEPTH(TURN_DEPTH)
  ) u_turns (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (fctl),
    .max_turns(max_turns_r),
    .stat     (fstat)
  );

  // button
  always_comb begin
    bcfg.click_min  = click_min_r;
    bcfg.click_max  = click_max_r;
    bcfg.hold_min   = hold_min_r;
    bcfg.clicks_gap = clicks_gap_r;

    bctl.valid      = acc;
    bctl.sample     = is_sample;
    bctl.turn       = turn_vld;
    bctl.level      = active;
    bctl.ack        = acc && (in_data.action == rebd_pkg::ACT_ACK);
    bctl.ack_mask   = in_data.ack_mask;
    bctl.inv_toggle = inv_toggle;
  end

  rebd_button u_button (
    .clk  (clk),
    .rst_n(rst_n),
    .cfg  (bcfg),
    .ctl  (bctl),
    .stat (bstat)
  );

  // result register
  always_comb begin
    out_data_nxt.turn_available   = fstat.avail;
    out_data_nxt.head_right       = fstat.head_right;
    out_data_nxt.head_with_button = fstat.head_btn;
    out_data_nxt.turns_stored     = fstat.stored;
    out_data_nxt.pressed_event    = bstat.pressed;
    out_data_nxt.click_event      = bstat.click;
    out_data_nxt.held_event       = bstat.held;
    out_data_nxt.click_count      = bstat.count;
    out_data_nxt.clicks_final     = bstat.final_flag;
  end

  always_comb begin
    priority if (acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `REBD_ASSERT_NEXT(a_acc_result, acc, out_valid_r, "accepted request produced no result")
  `REBD_ASSERT_NEXT(a_turn_clears, turn_vld, pulse_r == 8'd0, "pulse count kept after turn")
  `REBD_ASSERT_NEXT(a_decode_idle, !acc,
                    $stable(pulse_r) && $stable(prev_clk_r) && $stable(prev_dt_r),
                    "decoder state moved without a request")

endmodule
